// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`define ASSERT_ALWAYS(label, clk, rst_n, a)
`endif
`endif

// ----- rtl/core/hll_pkg.sv -----
// shared types and constants of the distinct counter
package hll_pkg;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        report;
    } in_item_t;

    typedef struct packed {
        logic [63:0] estimate;
        logic        saturated;
    } out_item_t;

    // ln2 in unsigned q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044471;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_SEL  = 8'b0000_0100,
        ST_NORM = 8'b0000_1000,
        ST_SQR  = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_ADD  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } est_state_t;

endpackage

// ----- rtl/core/hll_ram.sv -----
// generic single-port-write ram with registered read
module hll_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/hll_est.sv -----
// multi-cycle estimator: divide, log2 by squaring, ln2 scaling
module hll_est
    import hll_pkg::*;
#(
    parameter int P = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] sum,
    input  logic [P:0]  zero_cnt,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam logic [63:0] M = 64'd1 << P;
    localparam logic [63:0] ALPHA =
        (P == 4) ? (64'd673 << 30) / 64'd1000 :
        (P == 5) ? (64'd697 << 30) / 64'd1000 :
        (P == 6) ? (64'd709 << 30) / 64'd1000 :
        ((64'd7213 * M) << 30) / (64'd10000 * M + 64'd10790);
    localparam logic [63:0] NHI = ALPHA >> (31 - P);
    localparam logic [63:0] NLO = ALPHA << (P + 33);
    localparam logic [63:0] SMALL_LIM = (64'd5 * M) / 64'd2;
    localparam logic [63:0] LARGE_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 64'd30;
    localparam logic [5:0]  P_W = 6'(P);

    est_state_t  state_reg, state_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [P:0]  v_reg, v_next;
    logic [63:0] y_reg, y_next;
    logic [5:0]  k_reg, k_next;
    logic [37:0] lg_reg, lg_next;
    logic        small_reg, small_next;
    logic [63:0] plo_reg, plo_next;
    logic [38:0] phi_reg, phi_next;
    logic [63:0] est_reg, est_next;
    logic        sat_reg, sat_next;

    logic [64:0]  div_sh;
    logic [63:0]  sq;
    logic [38:0]  dlog;
    logic [70:0]  prod;
    logic [127:0] prod_ext;

    always_comb begin
        state_next = state_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        lg_next    = lg_reg;
        small_next = small_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        est_next   = est_reg;
        sat_next   = sat_reg;
        div_sh     = {rem_reg, NLO[cnt_reg]};
        sq         = y_reg[31:0] * y_reg[31:0];
        dlog       = (small_reg ? {1'b0, P_W, 32'd0} : {1'b1, 38'd0}) - {1'b0, lg_reg};
        prod       = {7'd0, plo_reg} + {phi_reg, 32'd0};
        prod_ext   = {57'd0, prod};

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    d_next   = sum;
                    v_next   = zero_cnt;
                    rem_next = NHI;
                    q_next   = '0;
                    cnt_next = 6'd63;
                    if (sum == 64'd0 || NHI >= sum) begin
                        est_next   = '1;
                        sat_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            // restoring division, one quotient bit per cycle
            ST_DIV: begin
                if (div_sh >= {1'b0, d_reg}) begin
                    rem_next = 64'(div_sh - {1'b0, d_reg});
                    q_next   = {q_reg[62:0], 1'b1};
                end else begin
                    rem_next = div_sh[63:0];
                    q_next   = {q_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = ST_SEL;
                end
            end
            // pick the range correction, or take the quotient as the estimate
            ST_SEL: begin
                k_next = 6'd63;
                if (v_reg != '0 && q_reg <= SMALL_LIM) begin
                    small_next = 1'b1;
                    y_next     = 64'(v_reg);
                    state_next = ST_NORM;
                end else if (q_reg > LARGE_LIM) begin
                    small_next = 1'b0;
                    y_next     = 64'd0 - q_reg;
                    state_next = ST_NORM;
                end else begin
                    est_next   = q_reg;
                    sat_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end
            // bring the leading one to the top, one bit per cycle
            ST_NORM: begin
                if (y_reg[63]) begin
                    y_next     = {32'd0, y_reg[63:32]};
                    lg_next    = {k_reg, 32'd0};
                    cnt_next   = 6'd31;
                    state_next = ST_SQR;
                end else begin
                    y_next = {y_reg[62:0], 1'b0};
                    k_next = k_reg - 6'd1;
                end
            end
            // one fraction bit of log2 per squaring
            ST_SQR: begin
                y_next = {32'd0, sq[63] ? sq[63:32] : sq[62:31]};
                lg_next[cnt_reg[4:0]] = sq[63];
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                plo_next   = dlog[31:0] * LN2_Q32;
                phi_next   = dlog[38:32] * LN2_Q32;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                state_next = ST_DONE;
                if (small_reg) begin
                    est_next = prod_ext[64-P +: 64];
                    sat_next = 1'b0;
                end else if (prod[70:64] != 7'd0) begin
                    est_next = '1;
                    sat_next = 1'b1;
                end else begin
                    est_next = prod[63:0];
                    sat_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        v_reg     <= v_next;
        y_reg     <= y_next;
        k_reg     <= k_next;
        lg_reg    <= lg_next;
        small_reg <= small_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        est_reg   <= est_next;
        sat_reg   <= sat_next;
    end

    assign m_valid          = (state_reg == ST_DONE);
    assign m_data.estimate  = est_reg;
    assign m_data.saturated = sat_reg;

endmodule

// ----- rtl/core/hyperloglog_distinct_counter_top.sv -----
// HyperLogLog distinct counter: rank update pipeline around the rank ram.
// After reset the rank ram is cleared one entry per cycle, with s_ready low.
// Hash transactions then enter one per cycle while no report is pending: the
// rank ram is read on acceptance and written back in the cycle after, with the
// previous write forwarded when both touch the same entry. A transaction that
// asks for a report holds s_ready low until its result is taken. The estimator
// is started through the s1 stage and start_reg. It saturates at once when the
// divide would overflow and takes the 64-step divider and a select step for a
// plain estimate. With a range correction these are followed by normalizing
// shifts, 32 squaring steps of log2, a multiply and an add.
module hyperloglog_distinct_counter_top
    import hll_pkg::*;
#(
    parameter int PRECISION_BITS = 14
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

`include "assert_macros.svh"

    localparam int P      = PRECISION_BITS;
    localparam int REST_W = 64 - P;
    localparam logic [P:0] M_CNT = (P+1)'(1) << P;
    localparam logic [5:0] TOP_R = 6'(63 - P);

    function automatic logic [63:0] term_of(input logic [5:0] r);
        if (r > TOP_R) begin
            return 64'd0;
        end
        return 64'd1 << (TOP_R - r);
    endfunction

    logic [P:0]   clr_cnt_reg;
    logic         clr_active;
    logic         busy_reg;
    logic         accept;
    logic [P-1:0] in_idx;
    logic [REST_W-1:0] rest;
    logic [5:0]   lz;
    logic [5:0]   in_rank;

    logic         s1_valid_reg;
    logic [P-1:0] s1_idx_reg;
    logic [5:0]   s1_rank_reg;
    logic         s1_report_reg;
    logic         fwd_valid_reg;
    logic [P-1:0] fwd_idx_reg;
    logic [5:0]   fwd_val_reg;
    logic         start_reg;

    logic [63:0]  sum_reg, sum_next;
    logic [P:0]   zero_reg, zero_next;

    logic [5:0]   ram_q;
    logic [5:0]   old_rank;
    logic         grow;
    logic         ram_we;
    logic [P-1:0] ram_waddr;
    logic [5:0]   ram_wdata;

    assign clr_active = !clr_cnt_reg[P];
    assign s_ready    = !clr_active && !busy_reg;
    assign accept     = s_valid && s_ready;

    // register index and rank of the incoming hash
    assign in_idx = s_data.hash_value[63 -: P];
    assign rest   = s_data.hash_value[REST_W-1:0];

    always_comb begin
        lz = 6'(REST_W);
        for (int i = 0; i < REST_W; i++) begin
            if (rest[i]) begin
                lz = 6'(REST_W - 1 - i);
            end
        end
        in_rank = (rest == '0) ? 6'(REST_W + 1) : lz + 6'd1;
    end

    // read-modify-write with forwarding of the last write
    assign old_rank = (fwd_valid_reg && fwd_idx_reg == s1_idx_reg) ? fwd_val_reg : ram_q;
    assign grow     = s1_valid_reg && (s1_rank_reg > old_rank);

    always_comb begin
        if (clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg[P-1:0];
            ram_wdata = 6'd0;
        end else begin
            ram_we    = grow;
            ram_waddr = s1_idx_reg;
            ram_wdata = s1_rank_reg;
        end
    end

    hll_ram #(
        .WIDTH (6),
        .DEPTH (1 << P)
    ) u_rank_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_idx),
        .rdata (ram_q)
    );

    // running inverse power sum and zero count
    always_comb begin
        sum_next  = sum_reg;
        zero_next = zero_reg;
        if (grow) begin
            sum_next = sum_reg - term_of(old_rank) + term_of(s1_rank_reg);
            if (old_rank == 6'd0) begin
                zero_next = zero_reg - (P+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            sum_reg       <= 64'd1 << 63;
            zero_reg      <= M_CNT;
        end else begin
            if (clr_active) begin
                clr_cnt_reg <= clr_cnt_reg + (P+1)'(1);
            end
            if (accept && s_data.report) begin
                busy_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                busy_reg <= 1'b0;
            end
            s1_valid_reg  <= accept;
            fwd_valid_reg <= grow;
            start_reg     <= s1_valid_reg && s1_report_reg;
            sum_reg       <= sum_next;
            zero_reg      <= zero_next;
        end
        s1_idx_reg    <= in_idx;
        s1_rank_reg   <= in_rank;
        s1_report_reg <= s_data.report;
        fwd_idx_reg   <= s1_idx_reg;
        fwd_val_reg   <= s1_rank_reg;
    end

    hll_est #(
        .P (P)
    ) u_est (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .sum      (sum_reg),
        .zero_cnt (zero_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `ASSERT_IMPLY(a_result_only_when_busy, aclk, aresetn, m_valid, busy_reg)
    `ASSERT_IMPLY(a_no_update_while_clearing, aclk, aresetn, clr_active, !s1_valid_reg)
    `ASSERT_NEXT(a_report_stalls_input, aclk, aresetn, accept && s_data.report, !s_ready)
    `ASSERT_ALWAYS(a_zero_count_bounded, aclk, aresetn, zero_reg <= M_CNT)

endmodule
